// ----- rtl/ccc_pkg.sv -----
// Package for the circle pair collision pipeline.
// Holds pipeline depths and the sideband structs; no dependencies.
package ccc_pkg;

  localparam int FRONT_STAGES = 4;
  localparam int SQRT_STAGES  = 32;
  localparam int DIV_STAGES   = 32;

  localparam logic signed [33:0] SAT_MAX = 34'sh07FFFFFFF;
  localparam logic signed [33:0] SAT_MIN = -34'sh080000000;

  typedef struct packed {
    logic               hit;
    logic               neg_x;
    logic               neg_y;
    logic        [31:0] ax;
    logic        [31:0] ay;
    logic        [31:0] sum;
    logic        [63:0] d2;
    logic        [62:0] px;
    logic        [62:0] py;
    logic signed [31:0] c2x;
    logic signed [31:0] c2y;
  } front_t;

  typedef struct packed {
    logic               hit;
    logic               neg_x;
    logic               neg_y;
    logic        [31:0] sum;
    logic        [31:0] span;
    logic signed [31:0] c2x;
    logic signed [31:0] c2y;
  } tail_t;

endpackage

// ----- rtl/ccc_if.sv -----
// Channel interfaces of the circle pair collision block.
// Depends on nothing; one interface for pairs in, one for results out.
interface ccc_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] center1_x;
  logic signed [31:0] center1_y;
  logic        [30:0] radius1;
  logic signed [31:0] center2_x;
  logic signed [31:0] center2_y;
  logic        [30:0] radius2;

  modport source(output valid, center1_x, center1_y, radius1, center2_x, center2_y,
                 radius2, input ready);
  modport sink(input valid, center1_x, center1_y, radius1, center2_x, center2_y,
               radius2, output ready);
endinterface

interface ccc_rsp_if;
  logic               valid;
  logic               ready;
  logic               colliding;
  logic        [31:0] depth;
  logic signed [17:0] normal_x;
  logic signed [17:0] normal_y;
  logic signed [31:0] contact_x;
  logic signed [31:0] contact_y;

  modport source(output valid, colliding, depth, normal_x, normal_y, contact_x, contact_y,
                 input ready);
  modport sink(input valid, colliding, depth, normal_x, normal_y, contact_x, contact_y,
               output ready);
endinterface

// ----- rtl/ccc_front.sv -----
// Front stages: differences, magnitudes, squares, radius products and the overlap test.
// Depends on ccc_pkg.
module ccc_front import ccc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] center1_x,
  input  logic signed [31:0] center1_y,
  input  logic        [30:0] radius1,
  input  logic signed [31:0] center2_x,
  input  logic signed [31:0] center2_y,
  input  logic        [30:0] radius2,
  output logic               out_valid,
  output front_t             out
);

  logic [FRONT_STAGES-1:0] valid;

  logic signed [32:0] dx1, dy1;
  logic        [31:0] sum1;
  logic        [30:0] r21;
  logic signed [31:0] c2x1, c2y1;

  logic        [31:0] ax2, ay2, sum2;
  logic               negx2, negy2, far2;
  logic        [30:0] r22;
  logic signed [31:0] c2x2, c2y2;

  logic        [63:0] sx3, sy3, ss3;
  logic        [62:0] px3, py3;
  logic        [31:0] ax3, ay3, sum3;
  logic               negx3, negy3, far3;
  logic signed [31:0] c2x3, c2y3;

  logic        [64:0] d2_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[FRONT_STAGES-2:0], in_valid};
    end
  end

  assign d2_wide = {1'b0, sx3} + {1'b0, sy3};

  always_ff @(posedge clk) begin
    if (en) begin
      dx1  <= {center1_x[31], center1_x} - {center2_x[31], center2_x};
      dy1  <= {center1_y[31], center1_y} - {center2_y[31], center2_y};
      sum1 <= {1'b0, radius1} + {1'b0, radius2};
      r21  <= radius2;
      c2x1 <= center2_x;
      c2y1 <= center2_y;

      negx2 <= dx1[32];
      negy2 <= dy1[32];
      ax2   <= dx1[32] ? 32'(-dx1) : dx1[31:0];
      ay2   <= dy1[32] ? 32'(-dy1) : dy1[31:0];
      sum2  <= sum1;
      r22   <= r21;
      c2x2  <= c2x1;
      c2y2  <= c2y1;
      far2  <= ((dx1[32] ? 33'(-dx1) : 33'(dx1)) > {1'b0, sum1}) ||
               ((dy1[32] ? 33'(-dy1) : 33'(dy1)) > {1'b0, sum1});

      sx3   <= 64'(ax2) * 64'(ax2);
      sy3   <= 64'(ay2) * 64'(ay2);
      ss3   <= 64'(sum2) * 64'(sum2);
      px3   <= 63'(ax2) * 63'(r22);
      py3   <= 63'(ay2) * 63'(r22);
      ax3   <= ax2;
      ay3   <= ay2;
      sum3  <= sum2;
      negx3 <= negx2;
      negy3 <= negy2;
      far3  <= far2;
      c2x3  <= c2x2;
      c2y3  <= c2y2;

      out.hit   <= !far3 && (d2_wide <= {1'b0, ss3});
      out.neg_x <= negx3;
      out.neg_y <= negy3;
      out.ax    <= ax3;
      out.ay    <= ay3;
      out.sum   <= sum3;
      out.d2    <= d2_wide[63:0];
      out.px    <= px3;
      out.py    <= py3;
      out.c2x   <= c2x3;
      out.c2y   <= c2y3;
    end
  end

  assign out_valid = valid[FRONT_STAGES-1];

endmodule

// ----- rtl/ccc_sqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
// Depends on ccc_pkg.
module ccc_sqrt import ccc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] value,
  output logic [31:0] root
);

  logic [33:0] rem  [SQRT_STAGES+1];
  logic [31:0] res  [SQRT_STAGES+1];
  logic [63:0] bits [SQRT_STAGES+1];

  assign rem[0]  = '0;
  assign res[0]  = '0;
  assign bits[0] = value;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [35:0] t;
    logic [35:0] trial;
    logic        ge;

    assign t     = {rem[k], bits[k][63:62]};
    assign trial = {2'b00, res[k], 2'b01};
    assign ge    = t >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? 34'(t - trial) : t[33:0];
        res[k+1]  <= {res[k][30:0], ge};
        bits[k+1] <= {bits[k][61:0], 2'b00};
      end
    end
  end

  assign root = res[SQRT_STAGES];

endmodule

// ----- rtl/ccc_div.sv -----
// Pipelined restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a stage.
// Depends on ccc_pkg; the quotient must fit in 32 bits.
module ccc_div import ccc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quotient
);

  logic [31:0] rem [DIV_STAGES+1];
  logic [31:0] low [DIV_STAGES+1];
  logic [31:0] dv  [DIV_STAGES+1];
  logic [31:0] q   [DIV_STAGES+1];

  assign rem[0] = dividend[63:32];
  assign low[0] = dividend[31:0];
  assign dv[0]  = divisor;
  assign q[0]   = '0;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [32:0] t;
    logic        ge;

    assign t  = {rem[k], low[k][31]};
    assign ge = t >= {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? 32'(t - {1'b0, dv[k]}) : t[31:0];
        low[k+1] <= {low[k][30:0], 1'b0};
        dv[k+1]  <= dv[k];
        q[k+1]   <= {q[k][30:0], ge};
      end
    end
  end

  assign quotient = q[DIV_STAGES];

endmodule

// ----- rtl/circle_circle_collision.sv -----
// Circle pair collision test, top level.
// Depends on ccc_pkg, ccc_if, ccc_front, ccc_sqrt and ccc_div.
//
// Usage: pairs of circles enter on req (centers and radii in Q15.16) and
// one result per pair leaves on rsp, in order. A transaction completes on
// a rising edge with valid and ready both high.
// The pipeline is four front stages (differences, squares, overlap test),
// 32 square root stages, 32 divider stages and the output register.
// Throughput is one pair per cycle while rsp takes results; the whole
// pipeline advances as one.
// When the receiver stalls with a result waiting, every stage holds and
// req.ready drops in the same cycle, so nothing is lost or repeated;
// ready returns as soon as rsp takes the waiting result.
// A synchronous reset clears all valid bits; the result payload is not
// cleared and is shown only with rsp.valid high.
module circle_circle_collision import ccc_pkg::*; (
  input logic       clk,
  input logic       rst,
  ccc_req_if.sink   req,
  ccc_rsp_if.source rsp
);

  logic   adv;
  logic   f_valid;
  front_t f_data;
  logic [31:0] sq_root;

  logic   sq_valid [SQRT_STAGES];
  front_t sq_side  [SQRT_STAGES];
  logic   dv_valid [DIV_STAGES];
  tail_t  dv_side  [DIV_STAGES];

  front_t mid;
  tail_t  t0;
  tail_t  tl;
  logic [31:0] qnx, qny, qcx, qcy;

  logic signed [33:0] px_pos, py_pos;
  logic signed [31:0] cx_sat, cy_sat;

  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  ccc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (req.valid),
    .center1_x(req.center1_x),
    .center1_y(req.center1_y),
    .radius1  (req.radius1),
    .center2_x(req.center2_x),
    .center2_y(req.center2_y),
    .radius2  (req.radius2),
    .out_valid(f_valid),
    .out      (f_data)
  );

  ccc_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .value(f_data.d2),
    .root (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SQRT_STAGES; i++) sq_valid[i] <= 1'b0;
      for (int i = 0; i < DIV_STAGES; i++) dv_valid[i] <= 1'b0;
    end else if (adv) begin
      sq_valid[0] <= f_valid;
      for (int i = 1; i < SQRT_STAGES; i++) sq_valid[i] <= sq_valid[i-1];
      dv_valid[0] <= sq_valid[SQRT_STAGES-1];
      for (int i = 1; i < DIV_STAGES; i++) dv_valid[i] <= dv_valid[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side[0] <= f_data;
      for (int i = 1; i < SQRT_STAGES; i++) sq_side[i] <= sq_side[i-1];
      dv_side[0] <= t0;
      for (int i = 1; i < DIV_STAGES; i++) dv_side[i] <= dv_side[i-1];
    end
  end

  assign mid = sq_side[SQRT_STAGES-1];

  always_comb begin
    t0.hit   = mid.hit;
    t0.neg_x = mid.neg_x;
    t0.neg_y = mid.neg_y;
    t0.sum   = mid.sum;
    t0.span  = sq_root;
    t0.c2x   = mid.c2x;
    t0.c2y   = mid.c2y;
  end

  ccc_div u_div_nx (
    .clk(clk), .en(adv), .dividend({16'd0, mid.ax, 16'd0}), .divisor(sq_root), .quotient(qnx)
  );
  ccc_div u_div_ny (
    .clk(clk), .en(adv), .dividend({16'd0, mid.ay, 16'd0}), .divisor(sq_root), .quotient(qny)
  );
  ccc_div u_div_cx (
    .clk(clk), .en(adv), .dividend({1'b0, mid.px}), .divisor(mid.sum), .quotient(qcx)
  );
  ccc_div u_div_cy (
    .clk(clk), .en(adv), .dividend({1'b0, mid.py}), .divisor(mid.sum), .quotient(qcy)
  );

  assign tl = dv_side[DIV_STAGES-1];

  assign px_pos = tl.neg_x ? 34'(tl.c2x) - $signed({2'b00, qcx})
                           : 34'(tl.c2x) + $signed({2'b00, qcx});
  assign py_pos = tl.neg_y ? 34'(tl.c2y) - $signed({2'b00, qcy})
                           : 34'(tl.c2y) + $signed({2'b00, qcy});

  always_comb begin
    if (px_pos > SAT_MAX) begin
      cx_sat = SAT_MAX[31:0];
    end else if (px_pos < SAT_MIN) begin
      cx_sat = SAT_MIN[31:0];
    end else begin
      cx_sat = px_pos[31:0];
    end
    if (py_pos > SAT_MAX) begin
      cy_sat = SAT_MAX[31:0];
    end else if (py_pos < SAT_MIN) begin
      cy_sat = SAT_MIN[31:0];
    end else begin
      cy_sat = py_pos[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= dv_valid[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!tl.hit) begin
        rsp.colliding <= 1'b0;
        rsp.depth     <= '0;
        rsp.normal_x  <= '0;
        rsp.normal_y  <= '0;
        rsp.contact_x <= '0;
        rsp.contact_y <= '0;
      end else if (tl.span == '0) begin
        rsp.colliding <= 1'b1;
        rsp.depth     <= tl.sum;
        rsp.normal_x  <= '0;
        rsp.normal_y  <= '0;
        rsp.contact_x <= tl.c2x;
        rsp.contact_y <= tl.c2y;
      end else begin
        rsp.colliding <= 1'b1;
        rsp.depth     <= tl.sum - tl.span;
        rsp.normal_x  <= tl.neg_x ? 18'(-qnx[17:0]) : qnx[17:0];
        rsp.normal_y  <= tl.neg_y ? 18'(-qny[17:0]) : qny[17:0];
        rsp.contact_x <= cx_sat;
        rsp.contact_y <= cy_sat;
      end
    end
  end

endmodule

// ----- rtl/ccc_checker.sv -----
// Port-level checks for the circle pair collision block, bound to the top level.
// Depends on the top level's ports only.
module ccc_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic               colliding,
  input logic        [31:0] depth,
  input logic signed [17:0] normal_x,
  input logic signed [17:0] normal_y,
  input logic signed [31:0] contact_x,
  input logic signed [31:0] contact_y
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(depth) && $stable(contact_x))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !colliding |-> depth == '0 && normal_x == '0 && normal_y == '0 &&
      contact_x == '0 && contact_y == '0)
    else $error("non-colliding result carries nonzero fields");

  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> normal_x <= 18'sd65536 && normal_x >= -18'sd65536 &&
      normal_y <= 18'sd65536 && normal_y >= -18'sd65536)
    else $error("normal component out of unit range");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    req_ready == (!rsp_valid || rsp_ready))
    else $error("input ready does not follow the output stall");

  a_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind circle_circle_collision ccc_checker u_ccc_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .colliding(rsp.colliding),
  .depth    (rsp.depth),
  .normal_x (rsp.normal_x),
  .normal_y (rsp.normal_y),
  .contact_x(rsp.contact_x),
  .contact_y(rsp.contact_y)
);

// ----- tb/tb_circle_circle_collision.sv -----
// Self-checking testbench for the circle pair collision pipeline.
// Depends on ccc_pkg, ccc_if and circle_circle_collision; holds its own collision predictor.
`timescale 1ns / 100ps

module tb_circle_circle_collision;
  import ccc_pkg::*;

  typedef struct {
    logic signed [31:0] c1x;
    logic signed [31:0] c1y;
    logic        [30:0] r1;
    logic signed [31:0] c2x;
    logic signed [31:0] c2y;
    logic        [30:0] r2;
  } pair_t;

  typedef struct {
    logic               hit;
    logic        [31:0] depth;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } contact_t;

  typedef struct {
    pair_t    p;
    logic     typed;
    contact_t want;
  } row_t;

  localparam int IDLE_LIMIT = 2000;
  localparam int N_RANDOM = 1725;

  logic clk = 1'b0;
  logic rst = 1'b1;
  ccc_req_if req();
  ccc_rsp_if rsp();

  circle_circle_collision dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always #2 clk = ~clk;

  contact_t pending_contacts[$];
  int n_errors = 0;
  int n_hits = 0;
  int n_results = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic stim_done = 1'b0;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] contact_coord(logic signed [31:0] c2, logic neg,
                                                       logic [63:0] mag, logic [63:0] r2,
                                                       logic [63:0] sum);
    logic signed [65:0] off;
    logic signed [65:0] p;
    off = $signed({2'b0, (mag * r2) / sum});
    p = neg ? (66'(c2) - off) : (66'(c2) + off);
    if (p > 66'sd2147483647) p = 66'sd2147483647;
    if (p < -66'sd2147483648) p = -66'sd2147483648;
    return p[31:0];
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    contact_t c;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic [63:0] ax;
    logic [63:0] ay;
    logic [63:0] sum;
    logic [64:0] d2;
    logic [63:0] span;
    logic [63:0] mx;
    logic [63:0] my;
    c = '{default: '0};
    dx = 34'(p.c1x) - 34'(p.c2x);
    dy = 34'(p.c1y) - 34'(p.c2y);
    ax = dx < 0 ? 64'(-dx) : 64'(dx);
    ay = dy < 0 ? 64'(-dy) : 64'(dy);
    sum = 64'(p.r1) + 64'(p.r2);
    if (ax > sum || ay > sum) return c;
    d2 = 65'(ax * ax) + 65'(ay * ay);
    if (d2 > 65'(sum * sum)) return c;
    span = int_sqrt(d2[63:0]);
    c.hit = 1'b1;
    c.depth = 32'(sum - span);
    if (span == 0) begin
      c.px = p.c2x;
      c.py = p.c2y;
      return c;
    end
    mx = (ax << 16) / span;
    my = (ay << 16) / span;
    c.nx = dx < 0 ? -18'(mx) : 18'(mx);
    c.ny = dy < 0 ? -18'(my) : 18'(my);
    c.px = contact_coord(p.c2x, dx < 0, ax, 64'(p.r2), sum);
    c.py = contact_coord(p.c2y, dy < 0, ay, 64'(p.r2), sum);
    return c;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 255)
                                     : 32'h80000000 + $urandom_range(0, 255);
      default: return 32'($signed($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 3))
      0: return 31'($urandom);
      1: return 31'($urandom_range(0, 1000000));
      2: return 31'h7FFFFFFF - 31'($urandom_range(0, 255));
      default: return 31'($urandom_range(0, 20000));
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    logic signed [31:0] off;
    p.c1x = rand_coord();
    p.c1y = rand_coord();
    p.r1 = rand_radius();
    p.r2 = rand_radius();
    if ($urandom_range(0, 99) < 70) begin
      // Place center 2 near center 1 so that most pairs collide or nearly do.
      off = 32'($signed($urandom_range(0, 2 * 20000)) - 20000);
      p.c2x = p.c1x + off;
      off = 32'($signed($urandom_range(0, 2 * 20000)) - 20000);
      p.c2y = p.c1y + off;
      if ($urandom_range(0, 9) == 0) begin
        p.c2x = p.c1x;
        p.c2y = p.c1y;
      end
    end else begin
      p.c2x = rand_coord();
      p.c2y = rand_coord();
    end
    return p;
  endfunction

  task automatic send_pair(pair_t p);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.center1_x <= p.c1x;
    req.center1_y <= p.c1y;
    req.radius1 <= p.r1;
    req.center2_x <= p.c2x;
    req.center2_y <= p.c2y;
    req.radius2 <= p.r2;
    pending_contacts.insert(pending_contacts.size(), predict_contact(p));
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (rsp.valid && rsp.ready) begin
        if (pending_contacts.size() == 0) begin
          $error("result transaction with nothing expected");
          n_errors++;
        end else begin
          contact_t w;
          w = pending_contacts.pop_front();
          check_field("colliding", 32'(w.hit), 32'(rsp.colliding));
          check_field("depth", w.depth, rsp.depth);
          check_field("normal_x", 32'(w.nx), 32'(rsp.normal_x));
          check_field("normal_y", 32'(w.ny), 32'(rsp.normal_y));
          check_field("contact_x", w.px, rsp.contact_x);
          check_field("contact_y", w.py, rsp.contact_y);
          n_results++;
          if (w.hit) n_hits++;
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", pending_contacts.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= !(recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct);
  end

  initial begin
    row_t rows[$];
    contact_t miss;
    contact_t got;
    int phase;
    miss = '{default: '0};
    req.valid = 1'b0;
    req.center1_x = '0;
    req.center1_y = '0;
    req.radius1 = '0;
    req.center2_x = '0;
    req.center2_y = '0;
    req.radius2 = '0;
    rsp.ready = 1'b0;
    // Both radii zero at one point: touching, zero normal, contact at center 2.
    rows.insert(rows.size(), '{'{0, 0, 0, 0, 0, 0}, 1, '{1, 0, 0, 0, 0, 0}});
    rows.insert(rows.size(), '{'{32'h12345, -32'sd7, 100, 32'h12345, -32'sd7, 50}, 1,
                               '{1, 150, 0, 0, 32'h12345, -32'sd7}});
    // Straight-line overlaps give exact unit normals.
    rows.insert(rows.size(), '{'{65536, 0, 65536, 0, 0, 65536}, 1,
                               '{1, 65536, 65536, 0, 32768, 0}});
    rows.insert(rows.size(), '{'{0, -65536, 65536, 0, 0, 65536}, 1,
                               '{1, 65536, 0, -65536, 0, -32768}});
    rows.insert(rows.size(), '{'{2, 0, 1, 0, 0, 1}, 1, '{1, 0, 65536, 0, 1, 0}});
    rows.insert(rows.size(), '{'{3, 0, 1, 0, 0, 1}, 1, miss});
    // Pairs at the extremes: far ones miss, no wrap of the squared distance.
    rows.insert(rows.size(), '{'{32'h7FFFFFFF, 32'h7FFFFFFF, 0, 32'h80000000, 32'h80000000,
                                 0}, 1, miss});
    rows.insert(rows.size(), '{'{32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF,
                                 32'h80000000, 32'h80000000, 31'h7FFFFFFF}, 0, miss});
    rows.insert(rows.size(), '{'{32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF,
                                 32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF}, 0, miss});
    rows.insert(rows.size(), '{'{32'h7FFFFFFF, 0, 31'h7FFFFFFF, 32'h80000000, 0,
                                 31'h7FFFFFFF}, 0, miss});
    rows.insert(rows.size(), '{'{32'h80000000, 32'h80000000, 31'h7FFFFFFF, 32'h7FFFFFFF,
                                 32'h7FFFFFFF, 0}, 0, miss});
    rows.insert(rows.size(), '{'{32'h80000000, 32'h80000000, 0, 32'h80000000, 32'h80000000,
                                 31'h7FFFFFFF}, 1,
                               '{1, 32'h7FFFFFFF, 0, 0, 32'h80000000, 32'h80000000}});
    rows.insert(rows.size(), '{'{-32'sd300000, 32'sd400000, 200000, 32'sd100000, -32'sd50000,
                                 500000}, 0, miss});
    rows.insert(rows.size(), '{'{32'sd5, 32'sd5, 3, 32'sd0, 32'sd0, 5}, 0, miss});
    rows.insert(rows.size(), '{'{32'hFFFFFFFF, 32'hAAAAAAAA, 31'h55555555, 32'h55555555,
                                 32'hAAAAAAAA, 31'h2AAAAAAA}, 0, miss});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        got = predict_contact(rows[i].p);
        if (got != rows[i].want) begin
          $error("typed row %0d disagrees with the predictor", i);
          n_errors++;
        end
      end
      send_pair(rows[i].p);
    end
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 35 : (phase == 1 ? 61 : 0);
      recv_idle_pct = phase == 0 ? 61 : (phase == 1 ? 35 : 0);
      for (int k = 0; k < N_RANDOM / 3; k++) begin
        send_pair(rand_pair());
        if ($urandom_range(0, 199) == 0) begin
          req.valid <= 1'b0;
          repeat ($urandom_range(1, 80)) @(negedge clk);
        end
      end
    end
    req.valid <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (pending_contacts.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("covered %0d pairs, %0d of them colliding, under three idle mixes",
             n_results, n_hits);
    if (n_errors == 0 && pending_contacts.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
